>>> hdl/pts_pkg.sv
package pts_pkg;

   localparam int SLOTS       = 16;
   localparam int MAX_RESULTS = 16;
   localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W       = $clog2(SLOTS + 1);
   localparam int RES_W       = $clog2(MAX_RESULTS + 1);

   localparam logic [1:0] OP_TICK     = 2'd0;
   localparam logic [1:0] OP_ADD      = 2'd1;
   localparam logic [1:0] OP_DELETE   = 2'd2;
   localparam logic [1:0] OP_DISPATCH = 2'd3;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NEGATIVE   = 3'd1;
   localparam logic [2:0] ST_FULL       = 3'd2;
   localparam logic [2:0] ST_NO_TASKS   = 3'd3;
   localparam logic [2:0] ST_CANNOT_DEL = 3'd4;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  task_tag;
      logic [31:0] start_delay;
      logic [31:0] repeat_period;
      logic [7:0]  slot_index;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] status;
      logic [4:0] slot_out;
      logic [7:0] tag_out;
      logic       ran;
      logic       last;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_ADD,
      CMD_DELETE,
      CMD_TICK_SLOT,
      CMD_DISPATCH_SLOT,
      CMD_DONE
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type       op;
      logic [IDX_W-1:0] idx;
      logic             last;
   } cmd_type;

   typedef struct packed {
      logic any_pend;
      logic pend_here;
      logic pend_above;
   } dp_status_type;

endpackage

>>> hdl/pts_if.sv
interface pts_req_if;
   import pts_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface pts_rsp_if;
   import pts_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/pts_ctrl.sv
module pts_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_opcode,
   output logic                  req_ready,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   input  pts_pkg::dp_status_type dp_status,
   output pts_pkg::cmd_type      cmd
);
   import pts_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_TICK,
      S_TICK_END,
      S_DISPATCH
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [RES_W-1:0] n_ff, n_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_free, load, last_rec;

   always_comb begin
      rsp_free  = !rsp_valid_ff || rsp_ready;
      state_in  = state_ff;
      idx_in    = idx_ff;
      n_in      = n_ff;
      load      = 1'b0;
      req_ready = 1'b0;
      last_rec  = !dp_status.pend_above || (n_ff == RES_W'(MAX_RESULTS - 1));
      cmd.op    = CMD_NONE;
      cmd.idx   = idx_ff;
      cmd.last  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = rsp_free;
            if (req_valid && rsp_free) begin
               case (req_opcode)
                  OP_TICK: begin
                     state_in = S_TICK;
                     idx_in   = '0;
                  end
                  OP_ADD: begin
                     cmd.op = CMD_ADD;
                     load   = 1'b1;
                  end
                  OP_DELETE: begin
                     cmd.op = CMD_DELETE;
                     load   = 1'b1;
                  end
                  default: begin
                     if (dp_status.any_pend) begin
                        state_in = S_DISPATCH;
                        idx_in   = '0;
                        n_in     = '0;
                     end else begin
                        cmd.op = CMD_DONE;
                        load   = 1'b1;
                     end
                  end
               endcase
            end
         end
         S_TICK: begin
            cmd.op = CMD_TICK_SLOT;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_W'(SLOTS - 1)) begin
               state_in = S_TICK_END;
            end
         end
         S_TICK_END: begin
            if (rsp_free) begin
               cmd.op   = CMD_DONE;
               load     = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DISPATCH: begin
            if (dp_status.pend_here) begin
               if (rsp_free) begin
                  cmd.op   = CMD_DISPATCH_SLOT;
                  cmd.last = last_rec;
                  load     = 1'b1;
                  n_in     = n_ff + 1'b1;
                  idx_in   = idx_ff + 1'b1;
                  if (last_rec) begin
                     state_in = S_IDLE;
                  end
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hdl/pts_datapath.sv
module pts_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  pts_pkg::cmd_type        cmd,
   input  pts_pkg::req_payload_type req_payload,
   output pts_pkg::rsp_payload_type rsp_payload,
   output pts_pkg::dp_status_type  dp_status
);
   import pts_pkg::*;

   logic             valid_ff [SLOTS];
   logic [7:0]       tag_ff [SLOTS];
   logic [31:0]      delay_ff [SLOTS];
   logic [31:0]      period_ff [SLOTS];
   logic [7:0]       run_ff [SLOTS];
   logic [CNT_W-1:0] count_ff;
   rsp_payload_type  rsp_ff, rsp_in;

   logic [SLOTS-1:0] pend;
   logic             free_found;
   logic [IDX_W-1:0] free_idx;
   logic             add_bad, del_ok;
   logic [IDX_W-1:0] del_idx;
   logic [31:0]      cur_delay, dec_delay, new_delay;
   logic [7:0]       new_run;
   logic             fire;

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int s = SLOTS - 1; s >= 0; s--) begin
         pend[s] = (run_ff[s] != 8'd0);
         if (!valid_ff[s]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(s);
         end
      end
      dp_status.any_pend   = |pend;
      dp_status.pend_here  = pend[cmd.idx];
      dp_status.pend_above = |((pend >> cmd.idx) >> 1);

      add_bad = req_payload.start_delay[31] || req_payload.repeat_period[31];
      del_idx = req_payload.slot_index[IDX_W-1:0];
      del_ok  = (32'(req_payload.slot_index) < 32'(SLOTS)) && valid_ff[del_idx];

      cur_delay = delay_ff[cmd.idx];
      dec_delay = (cur_delay != 32'd0) ? cur_delay - 32'd1 : cur_delay;
      fire      = valid_ff[cmd.idx] && (dec_delay == 32'd0);
      new_delay = (fire && (period_ff[cmd.idx] != 32'd0)) ? period_ff[cmd.idx] : dec_delay;
      new_run   = fire ? run_ff[cmd.idx] + 8'd1 : run_ff[cmd.idx];

      rsp_in      = rsp_ff;
      rsp_in.last = 1'b1;
      case (cmd.op)
         CMD_ADD: begin
            rsp_in = '{status: ST_OK, slot_out: '0, tag_out: '0, ran: 1'b0, last: 1'b1};
            if (add_bad) begin
               rsp_in.status = ST_NEGATIVE;
            end else if (!free_found) begin
               rsp_in.status   = ST_FULL;
               rsp_in.slot_out = 5'(SLOTS);
            end else begin
               rsp_in.slot_out = 5'(free_idx);
            end
         end
         CMD_DELETE: begin
            rsp_in = '{status: ST_OK, slot_out: '0, tag_out: '0, ran: 1'b0, last: 1'b1};
            if (count_ff == '0) begin
               rsp_in.status = ST_NO_TASKS;
            end else if (!del_ok) begin
               rsp_in.status = ST_CANNOT_DEL;
            end
         end
         CMD_DISPATCH_SLOT: begin
            rsp_in = '{status: ST_OK, slot_out: 5'(cmd.idx), tag_out: tag_ff[cmd.idx],
                       ran: 1'b1, last: cmd.last};
         end
         CMD_DONE: begin
            rsp_in = '{status: ST_OK, slot_out: '0, tag_out: '0, ran: 1'b0, last: 1'b1};
         end
         default: begin
            rsp_in = rsp_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) begin
            valid_ff[s]  <= 1'b0;
            tag_ff[s]    <= '0;
            delay_ff[s]  <= '0;
            period_ff[s] <= '0;
            run_ff[s]    <= '0;
         end
         count_ff <= '0;
      end else begin
         case (cmd.op)
            CMD_ADD: begin
               if (!add_bad && free_found) begin
                  valid_ff[free_idx]  <= 1'b1;
                  tag_ff[free_idx]    <= req_payload.task_tag;
                  delay_ff[free_idx]  <= req_payload.start_delay;
                  period_ff[free_idx] <= req_payload.repeat_period;
                  run_ff[free_idx]    <= '0;
                  count_ff            <= count_ff + 1'b1;
               end
            end
            CMD_DELETE: begin
               if (count_ff != '0 && del_ok) begin
                  valid_ff[del_idx]  <= 1'b0;
                  tag_ff[del_idx]    <= '0;
                  delay_ff[del_idx]  <= '0;
                  period_ff[del_idx] <= '0;
                  run_ff[del_idx]    <= '0;
                  count_ff           <= count_ff - 1'b1;
               end
            end
            CMD_TICK_SLOT: begin
               delay_ff[cmd.idx] <= new_delay;
               run_ff[cmd.idx]   <= new_run;
            end
            CMD_DISPATCH_SLOT: begin
               if (period_ff[cmd.idx] == 32'd0) begin
                  valid_ff[cmd.idx] <= 1'b0;
                  tag_ff[cmd.idx]   <= '0;
                  delay_ff[cmd.idx] <= '0;
                  run_ff[cmd.idx]   <= '0;
                  if (count_ff != '0) begin
                     count_ff <= count_ff - 1'b1;
                  end
               end else begin
                  run_ff[cmd.idx] <= run_ff[cmd.idx] - 8'd1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

endmodule

>>> hdl/periodic_task_slot_scheduler.sv
// Add and delete results are registered and shown the next cycle.
// Tick walks the slot table one slot per cycle; after the last slot it waits until the
// result register can move, then registers its result and returns to idle.
// Dispatch walks the table one slot per cycle, but stalls while a result cannot move on.
// A new transaction is accepted only in the idle state, while the result register can move.
// Synchronous active-high reset empties every slot and clears the task count.
module periodic_task_slot_scheduler (
   input logic       clock,
   input logic       reset,
   pts_req_if.sink   req_chan,
   pts_rsp_if.source rsp_chan
);
   import pts_pkg::*;

   cmd_type       cmd;
   dp_status_type dp_status;

   pts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.payload.opcode),
      .req_ready  (req_chan.ready),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .dp_status  (dp_status),
      .cmd        (cmd)
   );

   pts_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_chan.payload),
      .rsp_payload (rsp_chan.payload),
      .dp_status   (dp_status)
   );

endmodule

>>> bench/tb_top.sv
module tb_top;
   import pts_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock;
   logic reset;
   logic failed = 1'b0;
   int   cycle_count = 0;
   int   rsp_wait = 0;

   pts_req_if req_chan ();
   pts_rsp_if rsp_chan ();

   periodic_task_slot_scheduler dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   typedef struct {
      logic [1:0]  opcode;
      logic [7:0]  tag;
      logic [31:0] delay;
      logic [31:0] period;
      logic [7:0]  index;
      logic        has_fixed;
      logic [2:0]  fixed_status;
      logic [4:0]  fixed_slot;
   } stim_row_type;

   logic [0:SLOTS-1]        tbl_valid;
   logic [7:0]              tbl_tag [SLOTS];
   logic [31:0]             tbl_delay [SLOTS];
   logic [31:0]             tbl_period [SLOTS];
   logic [7:0]              tbl_runs [SLOTS];
   int                      tbl_count;
   rsp_payload_type         expected_rsp [$];
   stim_row_type            directed [$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("periodic_task_slot_scheduler: mismatch");
         $finish;
      end
   end

   function automatic rsp_payload_type make_rsp(logic [2:0] st, logic [4:0] sl,
                                                logic [7:0] tg, logic rn, logic lt);
      rsp_payload_type r;
      r.status   = st;
      r.slot_out = sl;
      r.tag_out  = tg;
      r.ran      = rn;
      r.last     = lt;
      return r;
   endfunction

   function automatic logic [7:0] predict_peek(req_payload_type p);
      int s;
      case (p.opcode)
         OP_ADD: begin
            if (p.start_delay[31] || p.repeat_period[31]) return {ST_NEGATIVE, 5'd0};
            for (s = 0; s < SLOTS; s++) if (!tbl_valid[s]) return {ST_OK, 5'(s)};
            return {ST_FULL, 5'(SLOTS)};
         end
         OP_DELETE: begin
            if (tbl_count == 0) return {ST_NO_TASKS, 5'd0};
            if (p.slot_index >= SLOTS || !tbl_valid[p.slot_index])
               return {ST_CANNOT_DEL, 5'd0};
            return {ST_OK, 5'd0};
         end
         default: return {ST_OK, 5'd0};
      endcase
   endfunction

   task automatic clear_slot(int s);
      tbl_valid[s]  = 1'b0;
      tbl_tag[s]    = '0;
      tbl_delay[s]  = '0;
      tbl_period[s] = '0;
      tbl_runs[s]   = '0;
      if (tbl_count > 0) tbl_count--;
   endtask

   task automatic predict_schedule(req_payload_type p);
      int s;
      int n;
      case (p.opcode)
         OP_TICK: begin
            for (s = 0; s < SLOTS; s++) begin
               if (tbl_delay[s] != 0) tbl_delay[s]--;
               if (tbl_valid[s] && tbl_delay[s] == 0) begin
                  tbl_runs[s]++;
                  if (tbl_period[s] != 0) tbl_delay[s] = tbl_period[s];
               end
            end
            expected_rsp.push_back(make_rsp(ST_OK, 0, 0, 0, 1));
         end
         OP_ADD: begin
            if (p.start_delay[31] || p.repeat_period[31]) begin
               expected_rsp.push_back(make_rsp(ST_NEGATIVE, 0, 0, 0, 1));
            end else begin
               for (s = 0; s < SLOTS; s++) if (!tbl_valid[s]) break;
               if (s == SLOTS) begin
                  expected_rsp.push_back(make_rsp(ST_FULL, 5'(SLOTS), 0, 0, 1));
               end else begin
                  tbl_valid[s]  = 1'b1;
                  tbl_tag[s]    = p.task_tag;
                  tbl_delay[s]  = p.start_delay;
                  tbl_period[s] = p.repeat_period;
                  tbl_runs[s]   = '0;
                  tbl_count++;
                  expected_rsp.push_back(make_rsp(ST_OK, 5'(s), 0, 0, 1));
               end
            end
         end
         OP_DELETE: begin
            if (tbl_count == 0) begin
               expected_rsp.push_back(make_rsp(ST_NO_TASKS, 0, 0, 0, 1));
            end else if (p.slot_index >= SLOTS || !tbl_valid[p.slot_index]) begin
               expected_rsp.push_back(make_rsp(ST_CANNOT_DEL, 0, 0, 0, 1));
            end else begin
               clear_slot(p.slot_index);
               expected_rsp.push_back(make_rsp(ST_OK, 0, 0, 0, 1));
            end
         end
         default: begin
            n = 0;
            for (s = 0; s < SLOTS && n < MAX_RESULTS; s++) begin
               if (tbl_runs[s] != 0) begin
                  tbl_runs[s]--;
                  expected_rsp.push_back(make_rsp(ST_OK, 5'(s), tbl_tag[s], 1, 0));
                  n++;
                  if (tbl_period[s] == 0) clear_slot(s);
               end
            end
            if (n == 0) expected_rsp.push_back(make_rsp(ST_OK, 0, 0, 0, 1));
            else expected_rsp[$].last = 1'b1;
         end
      endcase
   endtask

   task automatic send_transaction(req_payload_type p);
      int gap;
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= p;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_schedule(p);
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic add_row(logic [1:0] op, logic [7:0] tg, logic [31:0] dl,
                          logic [31:0] pr, logic [7:0] ix, logic fx,
                          logic [2:0] st, logic [4:0] sl);
      stim_row_type r;
      r.opcode = op; r.tag = tg; r.delay = dl; r.period = pr; r.index = ix;
      r.has_fixed = fx; r.fixed_status = st; r.fixed_slot = sl;
      directed.push_back(r);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected result %p", $time, rsp_chan.payload);
               failed <= 1'b1;
            end else begin
               if (rsp_chan.payload !== expected_rsp[0]) begin
                  $display("%0t: expected %p actual %p", $time, expected_rsp[0],
                           rsp_chan.payload);
                  failed <= 1'b1;
               end
               void'(expected_rsp.pop_front());
            end
            rsp_wait = $urandom_range(0, 10);
            if ($urandom_range(0, 3) == 0) rsp_wait = 0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_chan.ready <= (rsp_wait == 0);
      end
   end

   initial begin
      req_payload_type p;
      int i;
      int k;
      logic peek_failed;
      peek_failed      = 1'b0;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      for (i = 0; i < SLOTS; i++) begin
         tbl_valid[i] = 0; tbl_tag[i] = 0; tbl_delay[i] = 0;
         tbl_period[i] = 0; tbl_runs[i] = 0;
      end
      tbl_count = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      add_row(OP_DELETE, 0, 0, 0, 0, 1, ST_NO_TASKS, 0);
      add_row(OP_DISPATCH, 0, 0, 0, 0, 1, ST_OK, 0);
      add_row(OP_TICK, 0, 0, 0, 0, 1, ST_OK, 0);
      add_row(OP_ADD, 8'hff, 32'h8000_0000, 0, 0, 1, ST_NEGATIVE, 0);
      add_row(OP_ADD, 8'h00, 0, 32'hffff_ffff, 0, 1, ST_NEGATIVE, 0);
      add_row(OP_ADD, 8'hff, 0, 0, 0, 1, ST_OK, 0);
      add_row(OP_ADD, 8'h5a, 1, 2, 0, 1, ST_OK, 1);
      add_row(OP_ADD, 8'ha5, 32'h7fff_ffff, 32'h7fff_ffff, 0, 1, ST_OK, 2);
      add_row(OP_DELETE, 0, 0, 0, 8'hff, 1, ST_CANNOT_DEL, 0);
      add_row(OP_DELETE, 0, 0, 0, 8'd16, 1, ST_CANNOT_DEL, 0);
      add_row(OP_DELETE, 0, 0, 0, 8'd15, 1, ST_CANNOT_DEL, 0);
      add_row(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
      add_row(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
      add_row(OP_DISPATCH, 0, 0, 0, 0, 0, 0, 0);
      add_row(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
      add_row(OP_DELETE, 0, 0, 0, 8'd2, 1, ST_OK, 0);
      for (i = 0; i < 16; i++) add_row(OP_ADD, 8'(i * 17), 0, 1, 0, 0, 0, 0);
      add_row(OP_ADD, 8'h33, 0, 0, 0, 1, ST_FULL, 5'(SLOTS));
      add_row(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
      add_row(OP_DISPATCH, 0, 0, 0, 0, 0, 0, 0);

      foreach (directed[j]) begin
         p.opcode        = directed[j].opcode;
         p.task_tag      = directed[j].tag;
         p.start_delay   = directed[j].delay;
         p.repeat_period = directed[j].period;
         p.slot_index    = directed[j].index;
         if (directed[j].has_fixed &&
             (predict_peek(p) !== {directed[j].fixed_status, directed[j].fixed_slot})) begin
            $display("%0t: expected %0d/%0d actual predicted %0h", $time,
                     directed[j].fixed_status, directed[j].fixed_slot, predict_peek(p));
            peek_failed = 1'b1;
         end
         send_transaction(p);
      end

      drain_results();
      for (i = 0; i < SLOTS; i++) begin
         p = '0; p.opcode = OP_DELETE; p.slot_index = 8'(i);
         send_transaction(p);
      end

      for (k = 0; k < 230; k++) begin
         if (k == 115) drain_results();
         p.opcode        = 2'($urandom_range(0, 3));
         p.task_tag      = 8'($urandom);
         p.start_delay   = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6);
         p.repeat_period = ($urandom_range(0, 9) == 0) ? $urandom
                           : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 5));
         p.slot_index    = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                           : 8'($urandom_range(0, SLOTS - 1));
         send_transaction(p);
      end

      drain_results();
      repeat (40) @(posedge clock);
      if (!failed && !peek_failed) begin
         $display("periodic_task_slot_scheduler: match");
      end else begin
         $display("periodic_task_slot_scheduler: mismatch");
      end
      $finish;
   end
endmodule

>>> files.f
hdl/pts_pkg.sv
hdl/pts_if.sv
hdl/pts_ctrl.sv
hdl/pts_datapath.sv
hdl/periodic_task_slot_scheduler.sv
bench/tb_top.sv
